@@ design/assert_macros.svh @@
// Assertion helpers shared by the generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/swg_pkg.sv @@
// ----------------------------------------------------------------------------
// swg_pkg
// Shared types, register codes and the arctangent table of the sine generator.
// ----------------------------------------------------------------------------
package swg_pkg;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] REG_FREQUENCY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COMPARE   = 2'd1;

   // Field widths.
   localparam int FREQ_W     = 20;
   localparam int CMP_W      = 16;
   localparam int SAMPLE_W   = 12;
   localparam int POS_OUT_W  = 10;
   localparam int PHASE_W    = 16;
   localparam int XY_W       = 20;
   localparam int Z_W        = 32;
   localparam int STEPS      = 16;

   // Constants of the tone math.
   localparam logic [FREQ_W-1:0] TICK_RATE      = 20'd1000000;
   localparam logic [FREQ_W-1:0] RESET_FREQ     = 20'd1000;
   localparam logic [CMP_W-1:0]  RESET_COMPARE  = 16'd47;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 20'sd19898;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_ROT,
      ST_DONE
   } back_state_type;

   // Arctangent of 2^-k in binary angle units (2^32 per turn).
   function automatic logic signed [Z_W-1:0] atan_turn(input logic [3:0] k);
      logic signed [Z_W-1:0] a;
      case (k)
         4'd0:    a = 32'sh20000000;
         4'd1:    a = 32'sh12E4051E;
         4'd2:    a = 32'sh09FB385B;
         4'd3:    a = 32'sh051111D4;
         4'd4:    a = 32'sh028B0D43;
         4'd5:    a = 32'sh0145D7E1;
         4'd6:    a = 32'sh00A2F61E;
         4'd7:    a = 32'sh00517C55;
         4'd8:    a = 32'sh0028BE53;
         4'd9:    a = 32'sh00145F2F;
         4'd10:   a = 32'sh000A2F98;
         4'd11:   a = 32'sh000517CC;
         4'd12:   a = 32'sh00028BE6;
         4'd13:   a = 32'sh000145F3;
         4'd14:   a = 32'sh0000A2F9;
         default: a = 32'sh0000517C;
      endcase
      return a;
   endfunction

endpackage

@@ design/swg_fifo.sv @@
// ----------------------------------------------------------------------------
// swg_fifo
// Two-entry queue that carries sample jobs from the front to the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swg_fifo #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   logic [DATA_W-1:0] mem_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_SAME(a_no_overflow, clock, reset, push, !full, "push into a full queue")
   `ASSERT_SAME(a_no_underflow, clock, reset, pop, !empty, "pop from an empty queue")

endmodule

@@ design/swg_front.sv @@
// ----------------------------------------------------------------------------
// swg_front
// Takes ticks and register writes, runs the match counter and the sample
// index, and derives the period length with a serial divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swg_front #(
   parameter int TABLE_DEPTH = 1024,
   parameter int PW          = 10,
   parameter int NW          = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_run,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [swg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [swg_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                              job_push,
   output logic [PW+NW:0]                    job_data,
   input  logic                              job_full
);

   localparam int RESET_LEN = (TABLE_DEPTH < 1000) ? TABLE_DEPTH : 1000;
   localparam int FW        = swg_pkg::FREQ_W;

   logic [swg_pkg::CMP_W-1:0] cmp_ff, cmp_in;
   logic [swg_pkg::CMP_W-1:0] cnt_ff, cnt_in;
   logic [PW-1:0]             pos_ff, pos_in;
   logic [NW-1:0]             len_ff, len_in;
   logic [FW-1:0]             freq_ff, freq_in;
   logic                      busy_ff, busy_in;
   logic [4:0]                step_ff, step_in;
   logic [FW:0]               rem_ff, rem_in;
   logic [FW-1:0]             quo_ff, quo_in;

   logic          tick;
   logic          wrap;
   logic          csr_go;
   logic [NW-1:0] pos_ext;
   logic [NW-1:0] pos_inc;
   logic [FW:0]   rem_shift;
   logic          fits;
   logic [FW-1:0] quo_full;

   assign req_ready = !busy_ff && !job_full;
   assign csr_ready = !busy_ff;
   assign tick      = req_valid && req_ready && req_run;
   assign wrap      = tick && (cnt_ff >= cmp_ff);
   assign csr_go    = csr_valid && csr_ready;
   assign pos_ext   = NW'(pos_ff);
   assign pos_inc   = pos_ext + NW'(1);

   // A job carries the index, the period length and the end-of-period flag.
   assign job_push = wrap;
   assign job_data = {(pos_inc == len_ff), len_ff, pos_ff};

   // One restoring-division step of the tick rate by the frequency.
   assign rem_shift = {rem_ff[FW-1:0], quo_ff[FW-1]};
   assign fits      = (rem_shift >= {1'b0, freq_ff});
   assign quo_full  = {quo_ff[FW-2:0], fits};

   always_comb begin
      cmp_in  = cmp_ff;
      cnt_in  = cnt_ff;
      pos_in  = pos_ff;
      len_in  = len_ff;
      freq_in = freq_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;

      // Match counter and sample index.
      if (tick) begin
         if (wrap) begin
            cnt_in = '0;
            pos_in = (pos_inc >= len_ff) ? '0 : PW'(pos_inc);
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end

      // Period length divider.
      if (busy_ff) begin
         rem_in  = fits ? (rem_shift - {1'b0, freq_ff}) : rem_shift;
         quo_in  = quo_full;
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(FW - 1)) begin
            busy_in = 1'b0;
            if (quo_full > FW'(TABLE_DEPTH)) begin
               len_in = NW'(TABLE_DEPTH);
            end else if (quo_full == '0) begin
               len_in = NW'(1);
            end else begin
               len_in = NW'(quo_full);
            end
         end
      end

      // Register writes restart the counter and the index.
      if (csr_go) begin
         unique case (csr_index)
            swg_pkg::REG_FREQUENCY: begin
               freq_in = csr_data[FW-1:0];
               busy_in = 1'b1;
               step_in = '0;
               rem_in  = '0;
               quo_in  = swg_pkg::TICK_RATE;
               cnt_in  = '0;
               pos_in  = '0;
            end
            swg_pkg::REG_COMPARE: begin
               cmp_in = csr_data[swg_pkg::CMP_W-1:0];
               cnt_in = '0;
               pos_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_ff  <= swg_pkg::RESET_COMPARE;
         cnt_ff  <= '0;
         pos_ff  <= '0;
         len_ff  <= NW'(RESET_LEN);
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         cmp_ff  <= cmp_in;
         cnt_ff  <= cnt_in;
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff <= freq_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   `ASSERT_SAME(a_pos_in_period, clock, reset, !busy_ff, pos_ext < len_ff,
                "sample index outside the period")
   `ASSERT_SAME(a_no_tick_when_busy, clock, reset, busy_ff, !tick,
                "tick taken while the period length is being computed")

endmodule

@@ design/swg_back.sv @@
// ----------------------------------------------------------------------------
// swg_back
// Turns one queued job into a DAC code: phase division, CORDIC rotation,
// quadrant fold and scaling, then holds it in the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swg_back #(
   parameter int PW = 10,
   parameter int NW = 11
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            job_empty,
   input  logic [PW+NW:0]                  job_data,
   output logic                            job_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [swg_pkg::SAMPLE_W-1:0]    rsp_sample,
   output logic [swg_pkg::POS_OUT_W-1:0]   rsp_sample_position,
   output logic                            rsp_period_end
);

   localparam int XW = swg_pkg::XY_W;
   localparam int ZW = swg_pkg::Z_W;

   swg_pkg::back_state_type state_ff, state_in;

   logic [3:0]               step_ff, step_in;
   logic [PW-1:0]            pos_ff, pos_in;
   logic [NW-1:0]            len_ff, len_in;
   logic                     end_ff, end_in;
   logic [NW:0]              rem_ff, rem_in;
   logic [swg_pkg::PHASE_W-1:0] quo_ff, quo_in;
   logic [1:0]               quad_ff, quad_in;
   logic signed [XW-1:0]     x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]     z_ff, z_in;

   logic                     out_valid_ff, out_valid_in;
   logic [swg_pkg::SAMPLE_W-1:0]  sample_ff, sample_in;
   logic [swg_pkg::POS_OUT_W-1:0] opos_ff, opos_in;
   logic                     oend_ff, oend_in;

   logic [NW:0]              rem_shift;
   logic                     fits;
   logic [swg_pkg::PHASE_W-1:0] phase;
   logic signed [XW-1:0]     dx, dy;
   logic signed [XW-1:0]     fold;
   logic signed [15:0]       sat;
   logic [27:0]              scaled;
   logic                     load;

   // Phase division step: index * 2^16 / period, one quotient bit a cycle.
   assign rem_shift = {rem_ff[NW-1:0], 1'b0};
   assign fits      = (rem_shift >= {1'b0, len_ff});
   assign phase     = {quo_ff[swg_pkg::PHASE_W-2:0], fits};

   // CORDIC shifts for the current step.
   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;

   // Quadrant fold, saturation to Q1.15 and scaling to the DAC range.
   always_comb begin
      case (quad_ff)
         2'd0:    fold = y_ff;
         2'd1:    fold = x_ff;
         2'd2:    fold = -y_ff;
         default: fold = -x_ff;
      endcase
      if (fold > XW'(32767)) begin
         sat = 16'sh7FFF;
      end else if (fold < -XW'(32768)) begin
         sat = -16'sh8000;
      end else begin
         sat = fold[15:0];
      end
      scaled = 28'({~sat[15], sat[14:0]}) * 28'd4095 + 28'd32768;
   end

   assign load = (state_ff == swg_pkg::ST_DONE) && (!out_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swg_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Sequencer: pop, divide, rotate, deliver.
   always_comb begin
      state_in     = state_ff;
      job_pop      = 1'b0;
      step_in      = step_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      end_in       = end_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      quad_in      = quad_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      sample_in    = sample_ff;
      opos_in      = opos_ff;
      oend_in      = oend_ff;

      unique case (state_ff)
         swg_pkg::ST_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               pos_in   = job_data[PW-1:0];
               len_in   = job_data[PW+NW-1:PW];
               end_in   = job_data[PW+NW];
               rem_in   = (NW+1)'(job_data[PW-1:0]);
               quo_in   = '0;
               step_in  = '0;
               state_in = swg_pkg::ST_DIV;
            end
         end
         swg_pkg::ST_DIV: begin
            rem_in  = fits ? (rem_shift - {1'b0, len_ff}) : rem_shift;
            quo_in  = phase;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(swg_pkg::STEPS - 1)) begin
               quad_in  = phase[15:14];
               x_in     = swg_pkg::CORDIC_GAIN;
               y_in     = '0;
               z_in     = {2'b00, phase[13:0], 16'h0000};
               step_in  = '0;
               state_in = swg_pkg::ST_ROT;
            end
         end
         swg_pkg::ST_ROT: begin
            if (!z_ff[ZW-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - swg_pkg::atan_turn(step_ff);
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + swg_pkg::atan_turn(step_ff);
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(swg_pkg::STEPS - 1)) begin
               state_in = swg_pkg::ST_DONE;
            end
         end
         swg_pkg::ST_DONE: begin
            if (load) begin
               out_valid_in = 1'b1;
               sample_in    = scaled[27:16];
               opos_in      = swg_pkg::POS_OUT_W'(pos_ff);
               oend_in      = end_ff;
               state_in     = swg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      pos_ff    <= pos_in;
      len_ff    <= len_in;
      end_ff    <= end_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      quad_ff   <= quad_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      sample_ff <= sample_in;
      opos_ff   <= opos_in;
      oend_ff   <= oend_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_sample          = sample_ff;
   assign rsp_sample_position = opos_ff;
   assign rsp_period_end      = oend_ff;

   `ASSERT_NEXT(a_pop_starts_divide, clock, reset, job_pop, state_ff == swg_pkg::ST_DIV,
                "job popped without starting the phase division")
   `ASSERT_SAME(a_pop_only_idle, clock, reset, job_pop, state_ff == swg_pkg::ST_IDLE,
                "job popped while a sample is in progress")

endmodule

@@ design/sine_table_waveform_generator_core.sv @@
// ----------------------------------------------------------------------------
// sine_table_waveform_generator_core
// Tick-driven sine generator: a match counter paces DAC samples of one period.
// ----------------------------------------------------------------------------
// The block accepts one tick per cycle while its two-entry job queue has room
// and no period-length divide is running. Each counter wrap queues one sample
// job; the back end works on one job at a time: it takes the job, runs the
// phase division and 16 CORDIC steps, then loads the result register once the
// previous result is taken. When wraps come faster than that, the queue fills
// and ticks stall. A frequency write starts a serial divide for the period
// length, during which ticks and further writes wait.

module sine_table_waveform_generator_core #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_run,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [swg_pkg::SAMPLE_W-1:0]    rsp_sample,
   output logic [swg_pkg::POS_OUT_W-1:0]   rsp_sample_position,
   output logic                            rsp_period_end,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [swg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [swg_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int PW = $clog2(TABLE_DEPTH);
   localparam int NW = $clog2(TABLE_DEPTH + 1);

   logic             job_push;
   logic [PW+NW:0]   job_in;
   logic             job_full;
   logic             job_pop;
   logic [PW+NW:0]   job_out;
   logic             job_empty;

   // Front: tick counting, index and period length.
   swg_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .PW          (PW),
      .NW          (NW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_run   (req_run),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .job_push  (job_push),
      .job_data  (job_in),
      .job_full  (job_full)
   );

   // Job queue between the two halves.
   swg_fifo #(
      .DATA_W (PW + NW + 1)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out),
      .empty     (job_empty)
   );

   // Back: sine computation and result register.
   swg_back #(
      .PW (PW),
      .NW (NW)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .job_empty           (job_empty),
      .job_data            (job_out),
      .job_pop             (job_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sample          (rsp_sample),
      .rsp_sample_position (rsp_sample_position),
      .rsp_period_end      (rsp_period_end)
   );

endmodule
